// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/hrch_pkg.sv -----
// ----------------------------------------------------------------------------
// HID report command handler package
// Command codes, report kinds, reply constants and the beat types that the
// handler's datapath passes between its modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hrch_pkg;

   localparam int unsigned KEY_SLOT_COUNT_DEF = 6;
   localparam int unsigned MAX_KEY_SLOTS      = 6;
   localparam int unsigned PAY_BYTES          = 7;

   typedef enum logic [4:0] {
      CMD_MOVE       = 5'd0,
      CMD_MOUSE_FULL = 5'd1,
      CMD_BTN_LEFT   = 5'd2,
      CMD_BTN_RIGHT  = 5'd3,
      CMD_BTN_MIDDLE = 5'd4,
      CMD_BTN_SIDE1  = 5'd5,
      CMD_BTN_SIDE2  = 5'd6,
      CMD_WHEEL      = 5'd7,
      CMD_CLICK      = 5'd8,
      CMD_KEY_DOWN   = 5'd9,
      CMD_KEY_UP     = 5'd10,
      CMD_KEY_PRESS  = 5'd11,
      CMD_KBD_CLEAR  = 5'd12,
      CMD_KBD_STREAM = 5'd13,
      CMD_VERSION    = 5'd14,
      CMD_INFO       = 5'd15,
      CMD_BAUD       = 5'd16,
      CMD_REBOOT     = 5'd17,
      CMD_DEVICE     = 5'd18,
      CMD_ACK_ONLY   = 5'd19
   } cmd_type;

   typedef enum logic [1:0] {
      REPORT_NONE     = 2'd0,
      REPORT_MOUSE    = 2'd1,
      REPORT_KEYBOARD = 2'd2
   } report_type;

   localparam logic [2:0]  REPLY_LEN_OK      = 3'd1;
   localparam logic [2:0]  REPLY_LEN_VERSION = 3'd3;
   localparam logic [2:0]  REPLY_LEN_BAUD    = 3'd4;
   localparam logic [2:0]  REPLY_LEN_INFO    = 3'd5;
   localparam logic [39:0] REPLY_VERSION     = 40'h00_0039_2E33;
   localparam logic [39:0] REPLY_INFO        = 40'h74_7278_6D69;
   localparam logic [39:0] REPLY_BAUD        = 40'h00_0001_C200;
   localparam logic [39:0] REPLY_DEVICE      = 40'h00_0000_0001;

   typedef struct packed {
      logic [4:0]                    command;
      logic [3:0]                    payload_len;
      logic [PAY_BYTES-1:0][7:0]     pay;
   } req_type;

   typedef struct packed {
      logic       accepted;
      report_type report_kind;
      logic [7:0]  button_bits;
      logic [15:0] move_x;
      logic [15:0] move_y;
      logic [7:0]  wheel_step;
      logic        release_pending;
      logic [7:0]  modifier_bits;
      logic [47:0] key_slots_out;
      logic        reply_wanted;
      logic [2:0]  reply_len;
      logic [39:0] reply_bytes;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/hrch_exec.sv -----
// ----------------------------------------------------------------------------
// HID report command executor
// Decodes one command beat against the held button, modifier and key slot
// state, and produces the result beat together with the next state.
// ----------------------------------------------------------------------------
`default_nettype none

module hrch_exec #(
   parameter int unsigned KEY_SLOT_COUNT = hrch_pkg::KEY_SLOT_COUNT_DEF
) (
   input  hrch_pkg::req_type req_i,
   input  logic [7:0]        buttons_i,
   input  logic [7:0]        modifiers_i,
   input  logic [7:0]        slots_i [KEY_SLOT_COUNT],
   output hrch_pkg::rsp_type rsp_o,
   output logic [7:0]        buttons_o,
   output logic [7:0]        modifiers_o,
   output logic [7:0]        slots_o [KEY_SLOT_COUNT]
);
   import hrch_pkg::*;

   logic        ok;
   logic        is_mouse;
   logic        is_kbd;
   logic        slot_done;
   logic [7:0]  mask;
   logic [7:0]  click_mask;
   logic [2:0]  reply_len;
   logic [39:0] reply_bytes;
   logic [15:0] move_x;
   logic [15:0] move_y;
   logic [7:0]  wheel;
   logic        release_pending;
   logic [47:0] packed_slots;

   always_comb begin
      case (req_i.pay[0])
         8'd1:    click_mask = 8'h01;
         8'd2:    click_mask = 8'h02;
         8'd3:    click_mask = 8'h04;
         8'd4:    click_mask = 8'h08;
         8'd5:    click_mask = 8'h10;
         default: click_mask = 8'h00;
      endcase
   end

   always_comb begin
      ok              = 1'b1;
      is_mouse        = 1'b0;
      is_kbd          = 1'b0;
      slot_done       = 1'b0;
      mask            = 8'h01 << (req_i.command - 5'(CMD_BTN_LEFT));
      reply_len       = REPLY_LEN_OK;
      reply_bytes     = '0;
      move_x          = '0;
      move_y          = '0;
      wheel           = '0;
      release_pending = 1'b0;
      buttons_o       = buttons_i;
      modifiers_o     = modifiers_i;
      slots_o         = slots_i;
      case (cmd_type'(req_i.command))
         CMD_MOVE: begin
            if (req_i.payload_len < 4'd4) begin
               ok = 1'b0;
            end else begin
               move_x   = {req_i.pay[1], req_i.pay[0]};
               move_y   = {req_i.pay[3], req_i.pay[2]};
               is_mouse = 1'b1;
            end
         end
         CMD_MOUSE_FULL: begin
            if (req_i.payload_len < 4'd6) begin
               ok = 1'b0;
            end else begin
               buttons_o = req_i.pay[0];
               move_x    = {req_i.pay[2], req_i.pay[1]};
               move_y    = {req_i.pay[4], req_i.pay[3]};
               wheel     = req_i.pay[5];
               is_mouse  = 1'b1;
            end
         end
         CMD_BTN_LEFT, CMD_BTN_RIGHT, CMD_BTN_MIDDLE, CMD_BTN_SIDE1, CMD_BTN_SIDE2: begin
            if (req_i.payload_len == 4'd0) begin
               ok = 1'b0;
            end else begin
               if (req_i.pay[0] == 8'd1) begin
                  buttons_o = buttons_i | mask;
               end else begin
                  buttons_o = buttons_i & ~mask;
               end
               is_mouse = 1'b1;
            end
         end
         CMD_WHEEL: begin
            if (req_i.payload_len == 4'd0) begin
               ok = 1'b0;
            end else begin
               wheel    = req_i.pay[0];
               is_mouse = 1'b1;
            end
         end
         CMD_CLICK: begin
            if (req_i.payload_len == 4'd0 || click_mask == 8'h00) begin
               ok = 1'b0;
            end else begin
               buttons_o       = buttons_i | click_mask;
               release_pending = 1'b1;
               is_mouse        = 1'b1;
            end
         end
         CMD_KEY_DOWN, CMD_KEY_PRESS: begin
            if (req_i.payload_len == 4'd0) begin
               ok = 1'b0;
            end else begin
               for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
                  if (!slot_done) begin
                     if (slots_i[i] == req_i.pay[0]) begin
                        slot_done = 1'b1;
                     end else if (slots_i[i] == 8'd0) begin
                        slots_o[i] = req_i.pay[0];
                        slot_done  = 1'b1;
                     end
                  end
               end
               is_kbd = 1'b1;
            end
         end
         CMD_KEY_UP: begin
            if (req_i.payload_len == 4'd0) begin
               ok = 1'b0;
            end else begin
               for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
                  if (!slot_done && slots_i[i] == req_i.pay[0]) begin
                     slots_o[i] = 8'd0;
                     slot_done  = 1'b1;
                  end
               end
               is_kbd = 1'b1;
            end
         end
         CMD_KBD_CLEAR: begin
            modifiers_o = 8'd0;
            for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
               slots_o[i] = 8'd0;
            end
            is_kbd = 1'b1;
         end
         CMD_KBD_STREAM: begin
            if (req_i.payload_len == 4'd0) begin
               ok = 1'b0;
            end else begin
               modifiers_o = req_i.pay[0];
               for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
                  slots_o[i] = (4'(i + 1) < req_i.payload_len) ? req_i.pay[i + 1] : 8'd0;
               end
               is_kbd = 1'b1;
            end
         end
         CMD_VERSION: begin
            reply_len   = REPLY_LEN_VERSION;
            reply_bytes = REPLY_VERSION;
         end
         CMD_INFO: begin
            reply_len   = REPLY_LEN_INFO;
            reply_bytes = REPLY_INFO;
         end
         CMD_BAUD: begin
            if (req_i.payload_len == 4'd0) begin
               reply_len   = REPLY_LEN_BAUD;
               reply_bytes = REPLY_BAUD;
            end
         end
         CMD_DEVICE: begin
            reply_bytes = REPLY_DEVICE;
         end
         CMD_REBOOT, CMD_ACK_ONLY: begin
            reply_len = REPLY_LEN_OK;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      packed_slots = '0;
      for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
         packed_slots[8*i +: 8] = slots_o[i];
      end
   end

   always_comb begin
      rsp_o = '0;
      if (ok) begin
         rsp_o.accepted     = 1'b1;
         rsp_o.reply_wanted = 1'b1;
         rsp_o.reply_len    = reply_len;
         rsp_o.reply_bytes  = reply_bytes;
         if (is_mouse) begin
            rsp_o.report_kind     = REPORT_MOUSE;
            rsp_o.button_bits     = buttons_o;
            rsp_o.move_x          = move_x;
            rsp_o.move_y          = move_y;
            rsp_o.wheel_step      = wheel;
            rsp_o.release_pending = release_pending;
         end else if (is_kbd) begin
            rsp_o.report_kind   = REPORT_KEYBOARD;
            rsp_o.modifier_bits = modifiers_o;
            rsp_o.key_slots_out = packed_slots;
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/hid_report_command_handler_unit.sv -----
// The command register feeds the executor, whose result beat is registered.
// Throughput: one command per cycle unless stalled; the single-pass executor sits
// between the command register and the result register, so a stall holds both stages.
// Reset clears the held buttons, modifiers and key slots and drops any beat in flight.
// ----------------------------------------------------------------------------
// HID report command handler
// Keeps mouse buttons, keyboard modifiers and key slots, and turns each
// decoded command into one report and reply beat.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_report_command_handler_unit #(
   parameter int unsigned KEY_SLOT_COUNT = hrch_pkg::KEY_SLOT_COUNT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [4:0]         req_command,
   input  logic [3:0]         req_payload_len,
   input  logic [7:0]         req_pay0,
   input  logic [7:0]         req_pay1,
   input  logic [7:0]         req_pay2,
   input  logic [7:0]         req_pay3,
   input  logic [7:0]         req_pay4,
   input  logic [7:0]         req_pay5,
   input  logic [7:0]         req_pay6,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_accepted,
   output logic [1:0]         rsp_report_kind,
   output logic [7:0]         rsp_button_bits,
   output logic signed [15:0] rsp_move_x,
   output logic signed [15:0] rsp_move_y,
   output logic signed [7:0]  rsp_wheel_step,
   output logic               rsp_release_pending,
   output logic [7:0]         rsp_modifier_bits,
   output logic [47:0]        rsp_key_slots_out,
   output logic               rsp_reply_wanted,
   output logic [2:0]         rsp_reply_len,
   output logic [39:0]        rsp_reply_bytes
);
   import hrch_pkg::*;

   req_type    req_ff;
   logic       req_valid_ff;
   logic       req_valid_in;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       take;
   logic       advance;
   logic       out_open;
   logic [7:0] buttons_ff;
   logic [7:0] buttons_in;
   logic [7:0] modifiers_ff;
   logic [7:0] modifiers_in;
   logic [7:0] slots_ff [KEY_SLOT_COUNT];
   logic [7:0] slots_in [KEY_SLOT_COUNT];

   assign out_open     = !rsp_valid_ff || !rsp_stall;
   assign advance      = req_valid_ff && out_open;
   assign req_stall    = req_valid_ff && !out_open;
   assign take         = req_valid && !req_stall;
   assign req_valid_in = take || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   hrch_exec #(
      .KEY_SLOT_COUNT(KEY_SLOT_COUNT)
   ) u_exec (
      .req_i      (req_ff),
      .buttons_i  (buttons_ff),
      .modifiers_i(modifiers_ff),
      .slots_i    (slots_ff),
      .rsp_o      (rsp_in),
      .buttons_o  (buttons_in),
      .modifiers_o(modifiers_in),
      .slots_o    (slots_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         buttons_ff   <= '0;
         modifiers_ff <= '0;
         for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
            slots_ff[i] <= '0;
         end
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            buttons_ff   <= buttons_in;
            modifiers_ff <= modifiers_in;
            slots_ff     <= slots_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_ff.command     <= req_command;
         req_ff.payload_len <= req_payload_len;
         req_ff.pay         <= {req_pay6, req_pay5, req_pay4, req_pay3,
                                req_pay2, req_pay1, req_pay0};
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = rsp_ff.accepted;
   assign rsp_report_kind     = rsp_ff.report_kind;
   assign rsp_button_bits     = rsp_ff.button_bits;
   assign rsp_move_x          = rsp_ff.move_x;
   assign rsp_move_y          = rsp_ff.move_y;
   assign rsp_wheel_step      = rsp_ff.wheel_step;
   assign rsp_release_pending = rsp_ff.release_pending;
   assign rsp_modifier_bits   = rsp_ff.modifier_bits;
   assign rsp_key_slots_out   = rsp_ff.key_slots_out;
   assign rsp_reply_wanted    = rsp_ff.reply_wanted;
   assign rsp_reply_len       = rsp_ff.reply_len;
   assign rsp_reply_bytes     = rsp_ff.reply_bytes;

endmodule

`default_nettype wire

// ----- rtl/hrch_checker.sv -----
// ----------------------------------------------------------------------------
// HID report command handler checker
// Watches the result port for beats that break the handler's output rules.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hrch_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_accepted,
   input logic [1:0]         rsp_report_kind,
   input logic [7:0]         rsp_button_bits,
   input logic signed [15:0] rsp_move_x,
   input logic signed [15:0] rsp_move_y,
   input logic               rsp_release_pending,
   input logic [7:0]         rsp_modifier_bits,
   input logic [47:0]        rsp_key_slots_out,
   input logic               rsp_reply_wanted,
   input logic [2:0]         rsp_reply_len,
   input logic [39:0]        rsp_reply_bytes
);
   import hrch_pkg::*;

   `ASSERT_IMPL(a_reject_zero, clock, reset, rsp_valid && !rsp_accepted,
      rsp_report_kind == REPORT_NONE && !rsp_reply_wanted && rsp_reply_len == 3'd0 &&
      rsp_reply_bytes == 40'd0 && rsp_key_slots_out == 48'd0 && rsp_button_bits == 8'd0,
      "Rejected beat carries nonzero fields.")

   `ASSERT_IMPL(a_reply_len, clock, reset, rsp_valid && rsp_accepted,
      rsp_reply_wanted && rsp_reply_len != 3'd0 && rsp_reply_len <= 3'd5 &&
      (rsp_report_kind == REPORT_NONE || rsp_report_kind == REPORT_MOUSE ||
       rsp_report_kind == REPORT_KEYBOARD),
      "Accepted beat has a bad reply length or report kind.")

   `ASSERT_IMPL(a_kbd_fields, clock, reset, rsp_valid && rsp_report_kind != REPORT_KEYBOARD,
      rsp_modifier_bits == 8'd0 && rsp_key_slots_out == 48'd0,
      "Keyboard fields are set outside a keyboard report.")

   `ASSERT_IMPL(a_click_mouse, clock, reset, rsp_valid && rsp_release_pending,
      rsp_report_kind == REPORT_MOUSE && rsp_button_bits != 8'd0,
      "Pending release without a mouse report holding a button.")

   `ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_reply_bytes) && $stable(rsp_key_slots_out) &&
      $stable(rsp_move_x) && $stable(rsp_move_y),
      "Stalled result beat changed.")

endmodule

bind hid_report_command_handler_unit hrch_checker u_hrch_checker (.*);

`default_nettype wire
